// ----- hw/rtl/apd_pkg.sv -----
// alternating peak detector: shared widths, reset thresholds and event kind codes
// no dependencies
`timescale 1ns / 1ps

package apd_pkg;

   localparam int SAMPLE_WIDTH = 10;
   localparam int STEP_WIDTH   = 16;
   localparam int TIME_WIDTH   = 32;
   localparam int KIND_WIDTH   = 2;
   localparam int INDEX_WIDTH  = 2;

   localparam int REQ_DATA_WIDTH = 32;
   localparam int RSP_DATA_WIDTH = 48;

   localparam logic [SAMPLE_WIDTH-1:0] HIGH_RESET = 10'd520;
   localparam logic [SAMPLE_WIDTH-1:0] LOW_RESET  = 10'd512;

   localparam logic [INDEX_WIDTH-1:0] REG_HIGH_THRESHOLD = 2'd0;
   localparam logic [INDEX_WIDTH-1:0] REG_LOW_THRESHOLD  = 2'd1;

   localparam logic [KIND_WIDTH-1:0] KIND_PEAK       = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_VALLEY     = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_PEAK_FIX   = 2'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_VALLEY_FIX = 2'd3;

   localparam logic [1:0] SEEN_FULL = 2'd2;

endpackage

// ----- hw/rtl/alternating_peak_detector.sv -----
// alternating peak detector: window compare, running time and event output register
// depends on apd_pkg
`timescale 1ns / 1ps

// usage
// req channel: one word per record, sample and time step since the last record.
// rsp channel: one word per peak, valley or correction; kind in rsp_tuser,
//    running time and extreme value in rsp_tdata. records that cause no event
//    produce no word.
// csr channel: threshold writes, index 0 high threshold, index 1 low threshold;
//    always ready, other indexes ignored. write only while the block is idle.
// path: a record is held in the input register, then compare logic feeds the
//    result register that drives rsp.
// throughput: one record per cycle unless a result word waits, set by the single
//    compare and time add between the input register and the result register.
// reset: window, running time and extremes clear, a valley is sought first,
//    thresholds return to 520 and 512.
// stall: while a result word waits, one more record is held in the input
//    register; req_tready then drops until the result word is taken.

module alternating_peak_detector
   import apd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // sample [9:0], time_step [25:10], zero pad
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // event_time [31:0], event_value [41:32], zero pad
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   // event_kind [1:0]
   output logic [KIND_WIDTH-1:0]     rsp_tuser,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [INDEX_WIDTH-1:0]    csr_index,
   input  logic [SAMPLE_WIDTH-1:0]   csr_data
);

   logic [SAMPLE_WIDTH-1:0] high_ff;
   logic [SAMPLE_WIDTH-1:0] low_ff;

   logic                    s1_valid_ff;
   logic [SAMPLE_WIDTH-1:0] s1_sample_ff;
   logic [STEP_WIDTH-1:0]   s1_step_ff;

   logic [SAMPLE_WIDTH-1:0] prev_ff;
   logic [SAMPLE_WIDTH-1:0] older_ff;
   logic [1:0]              seen_ff;
   logic                    seek_ff;
   logic [TIME_WIDTH-1:0]   time_ff;
   logic [SAMPLE_WIDTH-1:0] peak_ff;
   logic [SAMPLE_WIDTH-1:0] valley_ff;
   logic                    have_peak_ff;
   logic                    have_valley_ff;

   logic                    rsp_valid_ff;
   logic [KIND_WIDTH-1:0]   rsp_kind_ff;
   logic [TIME_WIDTH-1:0]   rsp_time_ff;
   logic [SAMPLE_WIDTH-1:0] rsp_value_ff;

   logic                    advance;
   logic                    full;
   logic                    is_peak;
   logic                    is_valley;
   logic                    is_peak_fix;
   logic                    is_valley_fix;
   logic                    emit;
   logic [KIND_WIDTH-1:0]   kind_in;
   logic                    seek_in;
   logic [SAMPLE_WIDTH-1:0] peak_in;
   logic [SAMPLE_WIDTH-1:0] valley_in;
   logic                    have_peak_in;
   logic                    have_valley_in;
   logic [1:0]              seen_in;
   logic [TIME_WIDTH-1:0]   time_in;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - TIME_WIDTH - SAMPLE_WIDTH){1'b0}},
                        rsp_value_ff, rsp_time_ff};

   always_comb begin
      full          = (seen_ff == SEEN_FULL);
      is_peak       = full && !seek_ff && (prev_ff > high_ff) && (prev_ff > older_ff)
                      && (prev_ff >= s1_sample_ff);
      is_valley     = full && seek_ff && (prev_ff < low_ff) && (prev_ff <= older_ff)
                      && (prev_ff < s1_sample_ff);
      is_peak_fix   = full && !is_peak && !is_valley && seek_ff && have_peak_ff
                      && (prev_ff > peak_ff);
      is_valley_fix = full && !is_peak && !is_valley && !is_peak_fix && !seek_ff
                      && have_valley_ff && (prev_ff < valley_ff);
      emit          = is_peak || is_valley || is_peak_fix || is_valley_fix;

      kind_in        = KIND_VALLEY_FIX;
      seek_in        = seek_ff;
      peak_in        = peak_ff;
      valley_in      = valley_ff;
      have_peak_in   = have_peak_ff;
      have_valley_in = have_valley_ff;
      if (is_peak) begin
         kind_in      = KIND_PEAK;
         peak_in      = prev_ff;
         have_peak_in = 1'b1;
         seek_in      = 1'b1;
      end else if (is_valley) begin
         kind_in        = KIND_VALLEY;
         valley_in      = prev_ff;
         have_valley_in = 1'b1;
         seek_in        = 1'b0;
      end else if (is_peak_fix) begin
         kind_in = KIND_PEAK_FIX;
         peak_in = prev_ff;
      end else if (is_valley_fix) begin
         kind_in   = KIND_VALLEY_FIX;
         valley_in = prev_ff;
      end

      seen_in = full ? seen_ff : seen_ff + 2'd1;
      time_in = time_ff + {{(TIME_WIDTH - STEP_WIDTH){1'b0}}, s1_step_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff        <= HIGH_RESET;
         low_ff         <= LOW_RESET;
         s1_valid_ff    <= 1'b0;
         prev_ff        <= '0;
         older_ff       <= '0;
         seen_ff        <= '0;
         seek_ff        <= 1'b1;
         time_ff        <= '0;
         peak_ff        <= '0;
         valley_ff      <= '0;
         have_peak_ff   <= 1'b0;
         have_valley_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_HIGH_THRESHOLD) begin
               high_ff <= csr_data;
            end else if (csr_index == REG_LOW_THRESHOLD) begin
               low_ff <= csr_data;
            end
         end
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            older_ff       <= prev_ff;
            prev_ff        <= s1_sample_ff;
            seen_ff        <= seen_in;
            seek_ff        <= seek_in;
            time_ff        <= time_in;
            peak_ff        <= peak_in;
            valley_ff      <= valley_in;
            have_peak_ff   <= have_peak_in;
            have_valley_ff <= have_valley_in;
            rsp_valid_ff   <= emit;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_sample_ff <= req_tdata[SAMPLE_WIDTH-1:0];
         s1_step_ff   <= req_tdata[SAMPLE_WIDTH +: STEP_WIDTH];
      end
      if (advance && emit) begin
         rsp_kind_ff  <= kind_in;
         rsp_time_ff  <= time_ff;
         rsp_value_ff <= prev_ff;
      end
   end

   a_refill_needs_advance: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && s1_valid_ff) |-> advance)
      else $error("input register overwritten while its word was not consumed");

   a_no_event_before_window: assert property (@(posedge clock) disable iff (reset)
      (advance && !full) |=> !rsp_valid_ff)
      else $error("event produced before two samples were seen");

   a_peak_sets_seek: assert property (@(posedge clock) disable iff (reset)
      (advance && is_peak) |=> (seek_ff && have_peak_ff))
      else $error("new peak did not switch to seeking a valley");

   a_valley_fix_while_seeking_peak: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_VALLEY_FIX)) |-> (!seek_ff && have_valley_ff))
      else $error("valley correction reported while not seeking a peak");

   a_single_event_kind: assert property (@(posedge clock) disable iff (reset)
      $onehot0({is_peak, is_valley, is_peak_fix, is_valley_fix}))
      else $error("more than one event kind selected");

endmodule

// ----- test/tb.sv -----
// testbench for alternating_peak_detector: checks every event word against a local
// model of the peak and valley search, under random idling on both channels in all but the last two phases
// depends on apd_pkg and the alternating_peak_detector rtl
`timescale 1ns / 1ps

module tb
   import apd_pkg::*;
();

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int REQ_PAD     = REQ_DATA_WIDTH - SAMPLE_WIDTH - STEP_WIDTH;
   localparam int WAVE_ITEMS  = 305;
   localparam logic [INDEX_WIDTH-1:0] REG_SPARE_A = 2'd2;
   localparam logic [INDEX_WIDTH-1:0] REG_SPARE_B = 2'd3;

   typedef struct {
      logic [SAMPLE_WIDTH-1:0] sample;
      logic [STEP_WIDTH-1:0]   step;
   } sample_record_type;

   typedef struct {
      logic [KIND_WIDTH-1:0]   kind;
      logic [TIME_WIDTH-1:0]   ev_time;
      logic [SAMPLE_WIDTH-1:0] value;
   } extreme_event_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [KIND_WIDTH-1:0]     rsp_tuser;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [INDEX_WIDTH-1:0]    csr_index = '0;
   logic [SAMPLE_WIDTH-1:0]   csr_data = '0;

   sample_record_type record_queue[$];
   extreme_event_type event_queue[$];
   sample_record_type next_record;
   extreme_event_type want;

   // model state
   logic [SAMPLE_WIDTH-1:0] high_thr = HIGH_RESET;
   logic [SAMPLE_WIDTH-1:0] low_thr  = LOW_RESET;
   logic [SAMPLE_WIDTH-1:0] prev_s = '0;
   logic [SAMPLE_WIDTH-1:0] older_s = '0;
   logic [1:0]              seen_count = '0;
   logic                    seek_valley = 1'b1;
   logic [TIME_WIDTH-1:0]   run_time = '0;
   logic [SAMPLE_WIDTH-1:0] peak_val = '0;
   logic [SAMPLE_WIDTH-1:0] valley_val = '0;
   logic                    got_peak = 1'b0;
   logic                    got_valley = 1'b0;

   int send_idle = 0;
   int recv_stall = 0;
   int fail_count = 0;
   int records_taken = 0;
   int events_checked = 0;
   int kind_count[4] = '{0, 0, 0, 0};
   int cycle_count = 0;
   bit time_wrapped = 1'b0;

   alternating_peak_detector uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic void track_extremes(logic [SAMPLE_WIDTH-1:0] cur,
                                          logic [STEP_WIDTH-1:0] step);
      extreme_event_type ev;
      bit fire;
      fire = 1'b0;
      ev.kind = KIND_PEAK;
      if (seen_count == SEEN_FULL) begin
         if (!seek_valley && prev_s > high_thr && prev_s > older_s && prev_s >= cur) begin
            peak_val = prev_s;
            got_peak = 1'b1;
            seek_valley = 1'b1;
            ev.kind = KIND_PEAK;
            fire = 1'b1;
         end else if (seek_valley && prev_s < low_thr && prev_s <= older_s && prev_s < cur) begin
            valley_val = prev_s;
            got_valley = 1'b1;
            seek_valley = 1'b0;
            ev.kind = KIND_VALLEY;
            fire = 1'b1;
         end else if (seek_valley && got_peak && prev_s > peak_val) begin
            peak_val = prev_s;
            ev.kind = KIND_PEAK_FIX;
            fire = 1'b1;
         end else if (!seek_valley && got_valley && prev_s < valley_val) begin
            valley_val = prev_s;
            ev.kind = KIND_VALLEY_FIX;
            fire = 1'b1;
         end
      end
      if (fire) begin
         ev.ev_time = run_time;
         ev.value = prev_s;
         event_queue.push_back(ev);
      end
      older_s = prev_s;
      prev_s = cur;
      if (seen_count != SEEN_FULL)
         seen_count = seen_count + 2'd1;
      if ({1'b0, run_time} + step > {1'b0, {TIME_WIDTH{1'b1}}})
         time_wrapped = 1'b1;
      run_time = run_time + step;
   endfunction

   // driver: one word per accepted record, gaps at the sender's idle rate
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_extremes(req_tdata[SAMPLE_WIDTH-1:0],
                           req_tdata[SAMPLE_WIDTH+STEP_WIDTH-1:SAMPLE_WIDTH]);
            records_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (record_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
               next_record = record_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {{REQ_PAD{1'b0}}, next_record.step, next_record.sample};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each event word with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (event_queue.size() == 0) begin
               $error("event word with nothing expected: kind %0d time %0d value %0d",
                      rsp_tuser, rsp_tdata[TIME_WIDTH-1:0],
                      rsp_tdata[TIME_WIDTH+SAMPLE_WIDTH-1:TIME_WIDTH]);
               fail_count++;
            end else begin
               want = event_queue.pop_front();
               events_checked++;
               kind_count[want.kind]++;
               if (rsp_tuser !== want.kind) begin
                  $error("event_kind expected %0d got %0d", want.kind, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[TIME_WIDTH-1:0] !== want.ev_time) begin
                  $error("event_time expected %0d got %0d", want.ev_time,
                         rsp_tdata[TIME_WIDTH-1:0]);
                  fail_count++;
               end
               if (rsp_tdata[TIME_WIDTH+SAMPLE_WIDTH-1:TIME_WIDTH] !== want.value) begin
                  $error("event_value expected %0d got %0d", want.value,
                         rsp_tdata[TIME_WIDTH+SAMPLE_WIDTH-1:TIME_WIDTH]);
                  fail_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d events outstanding",
                  cycle_count, event_queue.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic push_record(int sample, int step);
      sample_record_type rec;
      rec.sample = SAMPLE_WIDTH'(sample);
      rec.step = STEP_WIDTH'(step);
      record_queue.push_back(rec);
   endtask

   task automatic write_reg(logic [INDEX_WIDTH-1:0] index, logic [SAMPLE_WIDTH-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      if (index == REG_HIGH_THRESHOLD)
         high_thr = data;
      else if (index == REG_LOW_THRESHOLD)
         low_thr = data;
   endtask

   // block idle: nothing queued or offered, no event outstanding, pipe drained
   task automatic settle();
      do @(negedge clock);
      while (record_queue.size() != 0 || req_tvalid || event_queue.size() != 0);
      repeat (6) @(posedge clock);
   endtask

   function automatic int clamp_sample(int v);
      if (v < 0)
         return 0;
      if (v > 1023)
         return 1023;
      return v;
   endfunction

   // triangle swings around the thresholds, with plateaus and stray noise words
   task automatic queue_wave(int count, int hi, int lo);
      int level;
      int target;
      int stride;
      int i;
      int r;
      bit rising;
      level = $urandom_range(1023);
      target = level;
      stride = 1;
      rising = 1'($urandom_range(1));
      for (i = 0; i < count; i++) begin
         if (level == target) begin
            rising = !rising;
            if (rising)
               target = clamp_sample(hi + int'($urandom_range(180)) - 60);
            else
               target = clamp_sample(lo - int'($urandom_range(180)) + 60);
            stride = $urandom_range(1, 40);
         end
         if ($urandom_range(99) < 8) begin
            next_record.sample = SAMPLE_WIDTH'($urandom_range(1023));
         end else begin
            if ($urandom_range(99) >= 15) begin
               if (rising)
                  level = (level + stride > target) ? target : level + stride;
               else
                  level = (level - stride < target) ? target : level - stride;
            end
            next_record.sample = SAMPLE_WIDTH'(level);
         end
         r = $urandom_range(9);
         if (r == 0)
            next_record.step = '0;
         else if (r == 1)
            next_record.step = '1;
         else
            next_record.step = STEP_WIDTH'($urandom_range(65535));
         record_queue.push_back(next_record);
      end
   endtask

   initial begin
      int phase_high[6];
      int phase_low[6];
      int p;
      phase_high = '{1023, 0, 700, 0, 520, 0};
      phase_low = '{0, 1023, 300, 0, 512, 0};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_idle = 12;
      recv_stall = 68;

      // reset thresholds: short window, valley then peak, both corrections,
      // plateaus and field extremes
      push_record(0, 0);
      push_record(1023, 65535);
      push_record(600, 1);
      push_record(100, 2);
      push_record(300, 3);
      push_record(50, 4);
      push_record(700, 5);
      push_record(1023, 6);
      push_record(1023, 7);
      push_record(0, 8);
      push_record(0, 9);
      push_record(5, 10);
      push_record(900, 11);
      push_record(800, 12);
      push_record(950, 13);
      push_record(400, 14);
      push_record(511, 15);
      push_record(511, 16);
      push_record(600, 17);
      push_record(1023, 65535);
      push_record(512, 0);
      push_record(1, 43690);
      push_record(1022, 21845);
      settle();

      for (p = 0; p < 6; p++) begin
         if (p == 2) begin
            send_idle = 68;
            recv_stall = 12;
         end
         if (p == 4) begin
            send_idle = 0;
            recv_stall = 0;
         end
         if (p == 3 || p == 5) begin
            phase_high[p] = $urandom_range(1023);
            phase_low[p] = $urandom_range(1023);
         end
         write_reg(REG_SPARE_A, SAMPLE_WIDTH'($urandom_range(1023)));
         write_reg(REG_HIGH_THRESHOLD, SAMPLE_WIDTH'(phase_high[p]));
         write_reg(REG_LOW_THRESHOLD, SAMPLE_WIDTH'(phase_low[p]));
         write_reg(REG_SPARE_B, SAMPLE_WIDTH'($urandom_range(1023)));
         queue_wave(WAVE_ITEMS, phase_high[p], phase_low[p]);
         settle();
      end

      repeat (10) @(posedge clock);
      if (event_queue.size() != 0) begin
         $error("%0d expected events never arrived", event_queue.size());
         fail_count++;
      end
      $display("%0d records, %0d events: %0d peaks, %0d valleys,",
               records_taken, events_checked, kind_count[KIND_PEAK],
               kind_count[KIND_VALLEY]);
      $display("   %0d peak fixes, %0d valley fixes",
               kind_count[KIND_PEAK_FIX], kind_count[KIND_VALLEY_FIX]);
      $display("threshold sets: reset, extreme, crossed, random; running time wrap seen: %0d",
               time_wrapped);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/apd_pkg.sv
hw/rtl/alternating_peak_detector.sv
test/tb.sv
